### rtl/dcts_pkg.sv
// Package for the directional cone target selector.
// Holds widths, request and status codes and the channel payload types.
// No dependencies; every other file but dcts_ram uses it.
package dcts_pkg;

  localparam int unsigned MaxEntries = 128;
  localparam int unsigned IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  localparam int unsigned IdW       = 32;
  localparam int unsigned CoordXW   = 10;
  localparam int unsigned CoordYW   = 9;
  localparam int unsigned CenterW   = CoordXW + CoordYW;
  localparam int unsigned AxisW     = 16;
  localparam int unsigned DzW       = 15;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned EntryCntW = 8;

  localparam int unsigned DeltaW = CoordXW + 1;
  localparam int unsigned ProdW  = DeltaW + AxisW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned SqW    = 2 * DeltaW;

  localparam logic [DzW-1:0] DeadZoneReset = DzW'(8000);

  localparam logic [1:0] ReqClear  = 2'd0;
  localparam logic [1:0] ReqAppend = 2'd1;
  localparam logic [1:0] ReqQuery  = 2'd2;

  localparam logic [StatusW-1:0] StAck      = 3'd0;
  localparam logic [StatusW-1:0] StFull     = 3'd1;
  localparam logic [StatusW-1:0] StCentered = 3'd2;
  localparam logic [StatusW-1:0] StLatched  = 3'd3;
  localparam logic [StatusW-1:0] StNone     = 3'd4;
  localparam logic [StatusW-1:0] StSelected = 3'd5;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IdW-1:0]          target_id;
    logic [CoordXW-1:0]      ctr_col;
    logic [CoordYW-1:0]      ctr_row;
    logic [CoordXW-1:0]      ptr_col;
    logic [CoordYW-1:0]      ptr_row;
    logic signed [AxisW-1:0] axis_x;
    logic signed [AxisW-1:0] axis_y;
    logic [IdW-1:0]          hovered_id;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [IdW-1:0]       chosen_id;
    logic [EntryCntW-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [CoordXW-1:0]      px;
    logic [CoordYW-1:0]      py;
    logic signed [AxisW-1:0] ax;
    logic signed [AxisW-1:0] ay;
    logic [IdW-1:0]          hov;
  } query_t;

  typedef struct packed {
    logic start;
    logic vld;
  } cone_ctl_t;

  typedef struct packed {
    logic           busy;
    logic           found;
    logic [IdW-1:0] id;
  } cone_res_t;

endpackage

### rtl/dcts_if.sv
// Channel interfaces of the cone target selector: request, result, dead-zone write.
// Each carries valid, ready and a payload; depends on dcts_pkg.
interface dcts_req_if;
  logic          valid;
  logic          ready;
  dcts_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dcts_rsp_if;
  logic          valid;
  logic          ready;
  dcts_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dcts_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dcts_pkg::DzW-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/directional_cone_target_select_top.sv
// Top level of the directional cone target selector: sequencer, target table, dead-zone register.
// Depends on dcts_pkg, dcts_if, dcts_ram and dcts_cone_unit.
//
//   port    kind         payload
//   req_i   sink         req_type, target_id, centre, pointer, axes, hovered_id
//   rsp_o   source       status, chosen_id, entry_count
//   cfg_i   sink         dead_zone (15 bits)
//
// Clear, append and settled queries pass from the request through the result register to the output register.
// A scanning query reads the N table entries in turn: the cone unit
// evaluates one entry per cycle from the table's read port, then drains.
// Reset empties the table, arms the latch and loads dead_zone with 8000.
// One finished result waits in the output register while the next request is taken;
// a further result holds until the output register drains.
module directional_cone_target_select_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  dcts_req_if.sink          req_i,
  dcts_rsp_if.source        rsp_o,
  dcts_cfg_if.sink          cfg_i
);
  import dcts_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_POST  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            latch_q, latch_d;
  logic [DzW-1:0]  dz_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic            out_vld_q, out_vld_d;
  query_t          qry_q, qry_d;
  rsp_t            res_q, res_d;
  rsp_t            out_q, out_d;

  logic            req_acc;
  logic            tbl_we;
  logic [AxisW:0]  ax_mag, ay_mag;
  logic            centred;
  logic [IdW-1:0]     rd_id;
  logic [CenterW-1:0] rd_ctr;
  cone_ctl_t       cone_ctl;
  cone_res_t       cone_res;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign ax_mag  = req_i.data.axis_x[AxisW-1]
                 ? (AxisW + 1)'(-$signed({req_i.data.axis_x[AxisW-1], req_i.data.axis_x}))
                 : {1'b0, req_i.data.axis_x};
  assign ay_mag  = req_i.data.axis_y[AxisW-1]
                 ? (AxisW + 1)'(-$signed({req_i.data.axis_y[AxisW-1], req_i.data.axis_y}))
                 : {1'b0, req_i.data.axis_y};
  assign centred = (ax_mag < {2'b0, dz_q}) && (ay_mag < {2'b0, dz_q});

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    latch_d   = latch_q;
    idx_d     = idx_q;
    qry_d     = qry_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    rd_vld_d  = 1'b0;
    tbl_we    = 1'b0;
    cone_ctl  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          res_d.status    = StAck;
          res_d.chosen_id = '0;
          state_d         = S_POST;
          unique case (req_i.data.req_type)
            ReqClear: begin
              count_d = '0;
            end
            ReqAppend: begin
              if (count_q < CntW'(MaxEntries)) begin
                tbl_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                res_d.status = StFull;
              end
            end
            ReqQuery: begin
              if (centred) begin
                latch_d      = 1'b0;
                res_d.status = StCentered;
              end else if (latch_q) begin
                res_d.status = StLatched;
              end else begin
                latch_d = 1'b1;
                if (count_q == '0) begin
                  res_d.status = StNone;
                end else begin
                  qry_d.px       = req_i.data.ptr_col;
                  qry_d.py       = req_i.data.ptr_row;
                  qry_d.ax       = req_i.data.axis_x;
                  qry_d.ay       = req_i.data.axis_y;
                  qry_d.hov      = req_i.data.hovered_id;
                  idx_d          = '0;
                  cone_ctl.start = 1'b1;
                  state_d        = S_SCAN;
                end
              end
            end
            default: begin
            end
          endcase
          res_d.entry_count = EntryCntW'(count_d);
        end
      end
      S_SCAN: begin
        rd_vld_d = 1'b1;
        if (CntW'(idx_q) + CntW'(1) == count_q) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !cone_res.busy) begin
          res_d.status    = cone_res.found ? StSelected : StNone;
          res_d.chosen_id = cone_res.found ? cone_res.id : '0;
          state_d         = S_POST;
        end
      end
      S_POST: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    cone_ctl.vld = rd_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      latch_q   <= 1'b0;
      dz_q      <= DeadZoneReset;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      latch_q   <= latch_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        dz_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q <= qry_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  dcts_ram #(
    .Width (IdW),
    .Depth (MaxEntries)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (req_i.data.target_id),
    .raddr_i (idx_q),
    .rdata_o (rd_id)
  );

  dcts_ram #(
    .Width (CenterW),
    .Depth (MaxEntries)
  ) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({req_i.data.ctr_row, req_i.data.ctr_col}),
    .raddr_i (idx_q),
    .rdata_o (rd_ctr)
  );

  dcts_cone_unit u_cone (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (cone_ctl),
    .qry_i     (qry_q),
    .ent_id_i  (rd_id),
    .ent_ctr_i (rd_ctr),
    .res_o     (cone_res)
  );

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("table count beyond capacity");

  a_chosen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status != StSelected)) |-> (out_q.chosen_id == '0))
    else $error("chosen id set without a selection");

  a_scan_latched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_DRAIN) |-> latch_q)
    else $error("scan running with latch armed");

  a_read_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ($past(state_q) == S_SCAN))
    else $error("table read outside a scan");

  a_scan_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(idx_q) < count_q))
    else $error("scan index beyond table count");

endmodule

### rtl/dcts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package needed.
module dcts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dcts_cone_unit.sv
// Per-entry cone test and nearest-target tracker, reused once per table entry.
// Stages: products, sums, best update. Depends on dcts_pkg.
module dcts_cone_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dcts_pkg::cone_ctl_t         ctl_i,
  input  dcts_pkg::query_t            qry_i,
  input  logic [dcts_pkg::IdW-1:0]    ent_id_i,
  input  logic [dcts_pkg::CenterW-1:0] ent_ctr_i,
  output dcts_pkg::cone_res_t         res_o
);
  import dcts_pkg::*;

  logic signed [AxisW-1:0]  ax, ay;
  logic signed [DeltaW-1:0] dx, dy;

  logic                    s1_vld_q, s1_skip_q;
  logic [IdW-1:0]          s1_id_q;
  logic signed [ProdW-1:0] s1_dxax_q, s1_dyay_q, s1_dxay_q, s1_dyax_q;
  logic signed [SqW-1:0]   s1_sqx_q, s1_sqy_q;

  logic signed [SumW-1:0] dot, crs;
  logic [SumW-1:0]        crs_mag;
  logic [SqW-1:0]         sq_len;

  logic                   s2_vld_q, s2_skip_q;
  logic [IdW-1:0]         s2_id_q;
  logic signed [SumW-1:0] s2_dot_q;
  logic [SumW-1:0]        s2_crs_q;
  logic [SqW-1:0]         s2_dist_q;

  logic           take;
  logic           found_q;
  logic [SqW-1:0] best_q;
  logic [IdW-1:0] id_q;

  assign ax = qry_i.ax;
  assign ay = qry_i.ay;
  assign dx = $signed({1'b0, ent_ctr_i[CoordXW-1:0]}) - $signed({1'b0, qry_i.px});
  assign dy = $signed({2'b0, ent_ctr_i[CenterW-1:CoordXW]}) - $signed({2'b0, qry_i.py});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      s1_vld_q <= ctl_i.vld;
      s2_vld_q <= s1_vld_q;
      if (ctl_i.start) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_skip_q <= (ent_id_i == qry_i.hov);
    s1_id_q   <= ent_id_i;
    s1_dxax_q <= dx * ax;
    s1_dyay_q <= dy * ay;
    s1_dxay_q <= dx * ay;
    s1_dyax_q <= dy * ax;
    s1_sqx_q  <= dx * dx;
    s1_sqy_q  <= dy * dy;
  end

  assign dot     = SumW'(s1_dxax_q) + SumW'(s1_dyay_q);
  assign crs     = SumW'(s1_dxay_q) - SumW'(s1_dyax_q);
  assign crs_mag = crs[SumW-1] ? $unsigned(-crs) : $unsigned(crs);
  assign sq_len  = $unsigned(s1_sqx_q) + $unsigned(s1_sqy_q);

  always_ff @(posedge clk_i) begin
    s2_skip_q <= s1_skip_q;
    s2_id_q   <= s1_id_q;
    s2_dot_q  <= dot;
    s2_crs_q  <= crs_mag;
    s2_dist_q <= sq_len;
  end

  assign take = s2_vld_q && !s2_skip_q && (s2_dot_q > 0)
             && (s2_crs_q <= $unsigned(s2_dot_q))
             && (!found_q || (s2_dist_q < best_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q <= s2_dist_q;
      id_q   <= s2_id_q;
    end
  end

  assign res_o.busy  = s1_vld_q | s2_vld_q;
  assign res_o.found = found_q;
  assign res_o.id    = id_q;

endmodule

### verif/directional_cone_target_select_top_tb.sv
// Testbench for directional_cone_target_select_top: directed and random request streams,
// checked against an in-bench predictor of the table, stick latch and cone search.
// Depends on dcts_pkg, the dcts channel interfaces and the RTL top level.
module directional_cone_target_select_top_tb;
  import dcts_pkg::*;

  typedef logic signed [AxisW-1:0] axis_t;

  localparam logic [1:0]  ReqSpare    = 2'd3;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned RandomItems = 1825;
  localparam int unsigned Phases      = 6;
  localparam int unsigned SettleGap   = 8;
  localparam int unsigned TailCycles  = 20;

  logic clk_i;
  logic rst_ni;

  dcts_req_if req_ch ();
  dcts_rsp_if rsp_ch ();
  dcts_cfg_if cfg_ch ();

  directional_cone_target_select_top uut (
    .clk_i,
    .rst_ni,
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  // predictor state
  logic [IdW-1:0]     tbl_id [MaxEntries];
  logic [CoordXW-1:0] tbl_x  [MaxEntries];
  logic [CoordYW-1:0] tbl_y  [MaxEntries];
  int unsigned        tbl_count;
  bit                 stick_held;
  logic [DzW-1:0]     dz_model;

  req_t        pending_requests [$];
  rsp_t        awaited_outcomes [$];
  rsp_t        want_rsp;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  // stimulus generator state
  int unsigned    queued_items;
  int unsigned    gen_dz;
  int             scene_px;
  int             scene_py;
  logic [IdW-1:0] scene_ids [$];
  int             scene_cx [$];
  int             scene_cy [$];

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic rsp_t cone_select_outcome(input req_t r);
    rsp_t   o;
    longint ax, ay, dx, dy, dot, crs, sq_len, best;
    bit     found;
    o = '0;
    o.status = StAck;
    case (r.req_type)
      ReqClear: tbl_count = 0;
      ReqAppend: begin
        if (tbl_count < MaxEntries) begin
          tbl_id[tbl_count] = r.target_id;
          tbl_x[tbl_count]  = r.ctr_col;
          tbl_y[tbl_count]  = r.ctr_row;
          tbl_count++;
        end else begin
          o.status = StFull;
        end
      end
      ReqQuery: begin
        ax = longint'($signed(r.axis_x));
        ay = longint'($signed(r.axis_y));
        if (magnitude(ax) < longint'(dz_model) && magnitude(ay) < longint'(dz_model)) begin
          stick_held = 1'b0;
          o.status = StCentered;
        end else if (stick_held) begin
          o.status = StLatched;
        end else begin
          stick_held = 1'b1;
          best = 64'h7FFF_FFFF;
          found = 1'b0;
          for (int i = 0; i < int'(tbl_count); i++) begin
            if (tbl_id[i] != r.hovered_id) begin
              dx = longint'(tbl_x[i]) - longint'(r.ptr_col);
              dy = longint'(tbl_y[i]) - longint'(r.ptr_row);
              dot = dx * ax + dy * ay;
              crs = dx * ay - dy * ax;
              sq_len = dx * dx + dy * dy;
              if (dot > 0 && magnitude(crs) <= dot && sq_len < best) begin
                best = sq_len;
                o.chosen_id = tbl_id[i];
                found = 1'b1;
              end
            end
          end
          o.status = found ? StSelected : StNone;
          if (!found) o.chosen_id = '0;
        end
      end
      default: ;
    endcase
    o.entry_count = EntryCntW'(tbl_count);
    return o;
  endfunction

  function automatic req_t any_request();
    req_t r;
    r.req_type   = 2'($urandom_range(3));
    r.target_id  = $urandom;
    r.ctr_col    = CoordXW'($urandom_range(639));
    r.ctr_row    = CoordYW'($urandom_range(479));
    r.ptr_col    = CoordXW'($urandom_range(639));
    r.ptr_row    = CoordYW'($urandom_range(479));
    r.axis_x     = AxisW'($urandom);
    r.axis_y     = AxisW'($urandom);
    r.hovered_id = $urandom;
    return r;
  endfunction

  function automatic void enqueue(input req_t r);
    pending_requests.push_back(r);
    if (r.req_type != ReqSpare) queued_items++;
  endfunction

  function automatic void queue_clear();
    req_t r;
    r = any_request();
    r.req_type = ReqClear;
    enqueue(r);
  endfunction

  function automatic void queue_append(input logic [IdW-1:0] id, input int cx, input int cy);
    req_t r;
    r = any_request();
    r.req_type  = ReqAppend;
    r.target_id = id;
    r.ctr_col   = CoordXW'(cx);
    r.ctr_row   = CoordYW'(cy);
    enqueue(r);
  endfunction

  function automatic void queue_query(input int px, input int py, input axis_t ax,
                                      input axis_t ay, input logic [IdW-1:0] hov);
    req_t r;
    r = any_request();
    r.req_type   = ReqQuery;
    r.ptr_col    = CoordXW'(px);
    r.ptr_row    = CoordYW'(py);
    r.axis_x     = ax;
    r.axis_y     = ay;
    r.hovered_id = hov;
    enqueue(r);
  endfunction

  function automatic axis_t centred_axis();
    int unsigned m;
    if (gen_dz == 0) return AxisW'($urandom);
    m = $urandom_range(gen_dz - 1);
    return $urandom_range(1) ? -axis_t'(m) : axis_t'(m);
  endfunction

  function automatic axis_t deflected_axis();
    int unsigned m;
    m = $urandom_range(32768, gen_dz);
    if (m == 32768) return axis_t'(16'h8000);
    return $urandom_range(1) ? -axis_t'(m) : axis_t'(m);
  endfunction

  function automatic logic [IdW-1:0] pick_hovered();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40 && scene_ids.size() != 0)
      return scene_ids[$urandom_range(scene_ids.size() - 1)];
    if (roll < 70) return '0;
    return $urandom;
  endfunction

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // One stick excursion: usually a centred request to re-arm, then held deflections.
  function automatic void queue_excursion();
    int unsigned holds, mode;
    int          px, py;
    axis_t       ax, ay;
    if ($urandom_range(99) < 80)
      queue_query(scene_px, scene_py, centred_axis(), centred_axis(), pick_hovered());
    holds = $urandom_range(4, 1);
    for (int i = 0; i < int'(holds); i++) begin
      mode = $urandom_range(3);
      case (mode)
        0: begin ax = deflected_axis(); ay = AxisW'($urandom); end
        1: begin ay = deflected_axis(); ax = AxisW'($urandom); end
        2: begin ax = deflected_axis(); ay = $urandom_range(1) ? ax : -ax; end
        default: begin ax = AxisW'($urandom); ay = AxisW'($urandom); end
      endcase
      px = scene_px;
      py = scene_py;
      if ($urandom_range(99) < 15) begin
        px = $urandom_range(639);
        py = $urandom_range(479);
      end
      queue_query(px, py, ax, ay, pick_hovered());
    end
  endfunction

  // A scene: usually a clear, then fill the table around a pointer, then a few excursions.
  function automatic void queue_scene(input bit overfill);
    int unsigned    n, roll, k;
    int             cx, cy;
    logic [IdW-1:0] id;
    if (overfill || $urandom_range(99) < 90) begin
      queue_clear();
      scene_ids.delete();
      scene_cx.delete();
      scene_cy.delete();
    end
    roll = $urandom_range(99);
    if (overfill || roll < 3) n = $urandom_range(135, 120);
    else if (roll < 13)       n = $urandom_range(40, 17);
    else                      n = $urandom_range(16);
    scene_px = $urandom_range(639);
    scene_py = $urandom_range(479);
    for (int i = 0; i < int'(n); i++) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        cx = clamp(scene_px + int'($urandom_range(160)) - 80, 639);
        cy = clamp(scene_py + int'($urandom_range(160)) - 80, 479);
      end else if (roll < 80 && scene_cx.size() != 0) begin
        k  = $urandom_range(scene_cx.size() - 1);
        cx = scene_cx[k];
        cy = scene_cy[k];
      end else begin
        cx = $urandom_range(639);
        cy = $urandom_range(479);
      end
      roll = $urandom_range(99);
      if (roll < 5) id = '0;
      else if (roll < 10 && scene_ids.size() != 0)
        id = scene_ids[$urandom_range(scene_ids.size() - 1)];
      else id = $urandom;
      queue_append(id, cx, cy);
      scene_ids.push_back(id);
      scene_cx.push_back(cx);
      scene_cy.push_back(cy);
    end
    n = $urandom_range(4, 1);
    for (int i = 0; i < int'(n); i++) queue_excursion();
  endfunction

  function automatic void queue_directed();
    req_t r;
    queue_query(320, 240, 16'sd20000, 16'sd0, '0);
    queue_query(320, 240, 16'sd20000, 16'sd0, '0);
    queue_query(320, 240, 16'sd0, 16'sd0, '0);
    queue_query(320, 240, 16'sd7999, -16'sd7999, '0);
    queue_query(320, 240, 16'sd8000, 16'sd0, '0);
    r = any_request();
    r.req_type = ReqSpare;
    enqueue(r);
    queue_clear();
    queue_append(32'h0000_0000, 0, 0);
    queue_append(32'hFFFF_FFFF, 639, 479);
    queue_append(32'h0A0A_0001, 330, 240);
    queue_append(32'h0B0B_0002, 330, 240);
    queue_append(32'h0C0C_0003, 320, 250);
    queue_query(320, 240, 16'sd0, 16'sd0, '0);
    queue_query(320, 240, 16'sd32767, 16'sd0, '0);
    queue_query(320, 240, 16'sd0, 16'sd0, '0);
    queue_query(320, 240, 16'sd32767, 16'sd0, 32'h0A0A_0001);
    queue_query(320, 240, 16'sd0, 16'sd0, '0);
    queue_query(320, 240, axis_t'(16'h8000), axis_t'(16'h8000), '0);
    queue_query(320, 240, 16'sd0, 16'sd0, '0);
    queue_query(320, 240, axis_t'(16'h8000), axis_t'(16'h8000), 32'd5);
    queue_query(320, 240, 16'sd0, 16'sd0, '0);
    queue_query(320, 240, 16'sd10000, 16'sd10000, 32'h0A0A_0001);
    queue_query(320, 240, 16'sd0, axis_t'(16'h8000), '0);
    queue_query(639, 479, 16'sd0, 16'sd0, '0);
    queue_query(639, 479, 16'sd0, 16'sd32767, '0);
  endfunction

  task automatic settle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || req_ch.valid || awaited_outcomes.size() != 0);
    repeat (SettleGap) @(negedge clk_i);
  endtask

  task automatic write_dead_zone(input logic [DzW-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    dz_model = value;
    gen_dz   = value;
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    rsp_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver: hold each request until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        awaited_outcomes.push_back(cone_select_outcome(req_ch.data));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.data  <= pending_requests.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result: status %0d chosen_id %h entry_count %0d",
                   $time, rsp_ch.data.status, rsp_ch.data.chosen_id, rsp_ch.data.entry_count);
          mismatches++;
        end else begin
          want_rsp = awaited_outcomes.pop_front();
          if (rsp_ch.data.status !== want_rsp.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want_rsp.status, rsp_ch.data.status);
            mismatches++;
          end
          if (rsp_ch.data.chosen_id !== want_rsp.chosen_id) begin
            $display("%0t: chosen_id expected %h actual %h",
                     $time, want_rsp.chosen_id, rsp_ch.data.chosen_id);
            mismatches++;
          end
          if (rsp_ch.data.entry_count !== want_rsp.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want_rsp.entry_count, rsp_ch.data.entry_count);
            mismatches++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned    quota;
    logic [DzW-1:0] phase_dz [Phases];
    tbl_count      = 0;
    stick_held     = 1'b0;
    dz_model       = DeadZoneReset;
    gen_dz         = DeadZoneReset;
    mismatches     = 0;
    quiet_cycles   = 0;
    queued_items   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    scene_px       = 320;
    scene_py       = 240;
    phase_dz[0] = '0;
    phase_dz[1] = 15'd32767;
    phase_dz[2] = DzW'($urandom_range(32767));
    phase_dz[3] = 15'd1;
    phase_dz[4] = DeadZoneReset;
    phase_dz[5] = DzW'($urandom_range(16000));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    for (int ph = 0; ph < int'(Phases); ph++) begin
      settle();
      write_dead_zone(phase_dz[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 6; sink_stall_pct = 6; end
      endcase
      quota = queued_items + RandomItems / Phases;
      if (ph == 0) queue_scene(1'b1);
      while (queued_items < quota) begin
        if ($urandom_range(99) < 6) enqueue(any_request());
        else queue_scene(1'b0);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && awaited_outcomes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
